// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the dispatcher RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ttd_pkg.sv =====
// Shared types and constants for the time-triggered task dispatcher.
// No dependencies; used by every module of the block.
package ttd_pkg;

    localparam int TASK_W    = 8;
    localparam int OFFSET_W  = 8;
    localparam int TIME_W    = 32;
    localparam int STAMP_W   = 24;
    localparam int POS_OUT_W = 6;
    localparam int GRP_OUT_W = 3;

    localparam logic [STAMP_W-1:0] STAMP_MAX  = 24'hFF_FFFF;
    localparam logic [TIME_W-1:0]  STAMP_STEP = 32'd2;

    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] due_time;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
        logic              cin;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              carry;
    } alu_res_t;

    typedef struct packed {
        logic                 valid;
        logic [TASK_W-1:0]    task_id;
        logic [POS_OUT_W-1:0] position;
        logic [GRP_OUT_W-1:0] group;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic busy;
        logic pend_valid;
    } status_t;

endpackage

// ===== hw/rtl/ttd_alu.sv =====
// Shared 32-bit add/subtract unit; carry out of a subtract with carry-in set means a >= b.
// Depends on ttd_pkg.
module ttd_alu (
    input  ttd_pkg::alu_req_t req,
    output ttd_pkg::alu_res_t res
);
    import ttd_pkg::*;

    logic [TIME_W-1:0] b_op;
    logic [TIME_W:0]   total;

    always_comb
    begin
        b_op      = req.sub ? ~req.b : req.b;
        total     = {1'b0, req.a} + {1'b0, b_op} + (TIME_W+1)'(req.cin);
        res.sum   = total[TIME_W-1:0];
        res.carry = total[TIME_W];
    end

endmodule

// ===== hw/rtl/ttd_entry_ram.sv =====
// Task table storage: one write port, one read port with registered data.
// Depends on ttd_pkg for the entry layout.
module ttd_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ttd_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output ttd_pkg::entry_t rdata
);
    import ttd_pkg::*;

    entry_t entry_mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ttd_seq.sv =====
// Dispatcher sequencer: table loading, group bookkeeping and the per-sample
// walk over all groups through the shared ALU. Depends on ttd_pkg, ttd_alu.
module ttd_seq #(
    parameter int TABLE_DEPTH = 64,
    parameter int GROUPS      = 8,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [1:0]                     kind,
    input  logic [ttd_pkg::TASK_W-1:0]     entry_task,
    input  logic [ttd_pkg::OFFSET_W-1:0]   entry_offset,
    input  logic [ttd_pkg::TIME_W-1:0]     entry_time,
    input  logic [ttd_pkg::STAMP_W-1:0]    counter_value,
    output logic                           mem_we,
    output logic [AW-1:0]                  mem_waddr,
    output ttd_pkg::entry_t                mem_wdata,
    output logic                           mem_re,
    output logic [AW-1:0]                  mem_raddr,
    input  ttd_pkg::entry_t                mem_rdata,
    input  logic                           out_free,
    output ttd_pkg::result_t               push,
    output ttd_pkg::status_t               status
);
    import ttd_pkg::*;

    localparam int LPW = $clog2(TABLE_DEPTH + 1);
    localparam int GCW = $clog2(GROUPS + 1);
    localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAMP,
        S_ORDER,
        S_DELTA,
        S_ACC,
        S_DUE,
        S_WRAP,
        S_FLUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [LPW-1:0]       load_ptr_reg, load_ptr_next;
    logic                 closed_reg, closed_next;
    logic [GCW-1:0]       grp_cnt_reg, grp_cnt_next;
    logic [AW-1:0]        grp_start_reg [GROUPS];
    logic [AW-1:0]        grp_start_next [GROUPS];
    logic [AW-1:0]        grp_end_reg [GROUPS];
    logic [AW-1:0]        grp_end_next [GROUPS];
    logic [AW-1:0]        grp_cursor_reg [GROUPS];
    logic [AW-1:0]        grp_cursor_next [GROUPS];
    logic [TIME_W-1:0]    grp_elapsed_reg [GROUPS];
    logic [TIME_W-1:0]    grp_elapsed_next [GROUPS];
    logic [STAMP_W-1:0]   prev_stamp_reg, prev_stamp_next;
    logic [STAMP_W-1:0]   sample_reg, sample_next;
    logic [STAMP_W-1:0]   cur_reg, cur_next;
    logic                 ge_reg, ge_next;
    logic [STAMP_W-1:0]   delta_reg, delta_next;
    logic [GCW-1:0]       g_reg, g_next;
    logic [TIME_W-1:0]    acc_reg, acc_next;
    logic                 fire_reg, fire_next;
    logic [TASK_W-1:0]    hit_task_reg, hit_task_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    result_t              pend_reg, pend_next;

    alu_req_t             alu_req;
    alu_res_t             alu_res;

    logic [GIW-1:0]       gi;
    logic [GIW-1:0]       load_gi;
    logic [AW-1:0]        pos_cur;
    logic [31:0]          pos_wide;
    logic [31:0]          grp_wide;
    logic                 room;
    logic                 push_old;

    ttd_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    always_comb
    begin
        gi       = g_reg[GIW-1:0];
        load_gi  = grp_cnt_reg[GIW-1:0];
        pos_cur  = grp_start_reg[gi] + grp_cursor_reg[gi];
        pos_wide = 32'(pos_cur);
        grp_wide = 32'(g_reg);
        room     = n_reg < RES_CNT_W'(MAX_RESULTS);
        push_old = fire_reg && room && pend_reg.valid;
    end

    always_comb
    begin
        state_next       = state_reg;
        load_ptr_next    = load_ptr_reg;
        closed_next      = closed_reg;
        grp_cnt_next     = grp_cnt_reg;
        grp_start_next   = grp_start_reg;
        grp_end_next     = grp_end_reg;
        grp_cursor_next  = grp_cursor_reg;
        grp_elapsed_next = grp_elapsed_reg;
        prev_stamp_next  = prev_stamp_reg;
        sample_next      = sample_reg;
        cur_next         = cur_reg;
        ge_next          = ge_reg;
        delta_next       = delta_reg;
        g_next           = g_reg;
        acc_next         = acc_reg;
        fire_next        = fire_reg;
        hit_task_next    = hit_task_reg;
        n_next           = n_reg;
        pend_next        = pend_reg;

        mem_we             = 1'b0;
        mem_waddr          = load_ptr_reg[AW-1:0];
        mem_wdata.task_id  = entry_task;
        mem_wdata.due_time = entry_time;
        mem_re             = 1'b0;
        mem_raddr          = pos_cur;
        push               = '0;

        alu_req.a   = acc_reg;
        alu_req.b   = mem_rdata.due_time;
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_LOAD:
                        begin
                            if (!closed_reg && load_ptr_reg < LPW'(TABLE_DEPTH))
                            begin
                                mem_we        = 1'b1;
                                load_ptr_next = load_ptr_reg + 1'b1;
                                if (entry_task != '0 && entry_offset == '0)
                                begin
                                    if (grp_cnt_reg < GCW'(GROUPS))
                                    begin
                                        grp_start_next[load_gi] = load_ptr_reg[AW-1:0];
                                    end
                                end
                                else if (entry_task == '0 && entry_offset != '0)
                                begin
                                    // close the open group at this end marker
                                    if (grp_cnt_reg < GCW'(GROUPS))
                                    begin
                                        grp_end_next[load_gi]     = load_ptr_reg[AW-1:0];
                                        grp_cursor_next[load_gi]  = '0;
                                        grp_elapsed_next[load_gi] = '0;
                                        grp_cnt_next              = grp_cnt_reg + 1'b1;
                                    end
                                end
                                else if (entry_task == '0 && entry_offset == '0)
                                begin
                                    closed_next = 1'b1;
                                end
                            end
                        end
                        KIND_SAMPLE:
                        begin
                            sample_next = counter_value;
                            n_next      = '0;
                            state_next  = S_STAMP;
                        end
                        KIND_CLEAR:
                        begin
                            load_ptr_next = '0;
                            closed_next   = 1'b0;
                            grp_cnt_next  = '0;
                            for (int i = 0; i < GROUPS; i++)
                            begin
                                grp_start_next[i]   = '0;
                                grp_end_next[i]     = '0;
                                grp_cursor_next[i]  = '0;
                                grp_elapsed_next[i] = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_STAMP:
            begin
                // step the sample down by two, wrap to full scale below two
                alu_req.a  = TIME_W'(sample_reg);
                alu_req.b  = STAMP_STEP;
                cur_next   = alu_res.carry ? alu_res.sum[STAMP_W-1:0] : STAMP_MAX;
                state_next = S_ORDER;
            end
            S_ORDER:
            begin
                alu_req.a  = TIME_W'(cur_reg);
                alu_req.b  = TIME_W'(prev_stamp_reg);
                ge_next    = alu_res.carry;
                state_next = S_DELTA;
            end
            S_DELTA:
            begin
                // on wrap the elapsed count is one less than the plain difference
                alu_req.a       = TIME_W'(prev_stamp_reg);
                alu_req.b       = TIME_W'(cur_reg);
                alu_req.cin     = !ge_reg;
                delta_next      = alu_res.sum[STAMP_W-1:0];
                prev_stamp_next = cur_reg;
                g_next          = '0;
                state_next      = (grp_cnt_reg == '0) ? S_IDLE : S_ACC;
            end
            S_ACC:
            begin
                alu_req.a   = grp_elapsed_reg[gi];
                alu_req.b   = TIME_W'(delta_reg);
                alu_req.sub = 1'b0;
                alu_req.cin = 1'b0;
                acc_next    = alu_res.sum;
                mem_re      = 1'b1;
                mem_raddr   = pos_cur;
                state_next  = S_DUE;
            end
            S_DUE:
            begin
                fire_next     = alu_res.carry;
                hit_task_next = mem_rdata.task_id;
                mem_re        = 1'b1;
                mem_raddr     = grp_end_reg[gi];
                state_next    = S_WRAP;
            end
            S_WRAP:
            begin
                // hold while an older result cannot leave
                if (!(push_old && !out_free))
                begin
                    grp_elapsed_next[gi] = acc_reg;
                    if (fire_reg)
                    begin
                        if ((AW+1)'(pos_cur) + 1'b1 < (AW+1)'(grp_end_reg[gi]))
                        begin
                            grp_cursor_next[gi] = grp_cursor_reg[gi] + 1'b1;
                        end
                        else
                        begin
                            grp_cursor_next[gi] = '0;
                        end
                        if (alu_res.carry)
                        begin
                            grp_elapsed_next[gi] = '0;
                        end
                    end
                    if (fire_reg && room)
                    begin
                        if (push_old)
                        begin
                            push      = pend_reg;
                            push.last = 1'b0;
                        end
                        pend_next.valid    = 1'b1;
                        pend_next.task_id  = hit_task_reg;
                        pend_next.position = pos_wide[POS_OUT_W-1:0];
                        pend_next.group    = grp_wide[GRP_OUT_W-1:0];
                        pend_next.last     = 1'b0;
                        n_next             = n_reg + 1'b1;
                    end
                    if (g_reg + 1'b1 < grp_cnt_reg)
                    begin
                        g_next     = g_reg + 1'b1;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_reg.valid)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push            = pend_reg;
                    push.last       = 1'b1;
                    pend_next.valid = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_ptr_reg   <= '0;
            closed_reg     <= 1'b0;
            grp_cnt_reg    <= '0;
            for (int i = 0; i < GROUPS; i++)
            begin
                grp_start_reg[i]   <= '0;
                grp_end_reg[i]     <= '0;
                grp_cursor_reg[i]  <= '0;
                grp_elapsed_reg[i] <= '0;
            end
            prev_stamp_reg <= STAMP_MAX;
            sample_reg     <= '0;
            cur_reg        <= '0;
            ge_reg         <= 1'b0;
            delta_reg      <= '0;
            g_reg          <= '0;
            acc_reg        <= '0;
            fire_reg       <= 1'b0;
            hit_task_reg   <= '0;
            n_reg          <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            load_ptr_reg    <= load_ptr_next;
            closed_reg      <= closed_next;
            grp_cnt_reg     <= grp_cnt_next;
            grp_start_reg   <= grp_start_next;
            grp_end_reg     <= grp_end_next;
            grp_cursor_reg  <= grp_cursor_next;
            grp_elapsed_reg <= grp_elapsed_next;
            prev_stamp_reg  <= prev_stamp_next;
            sample_reg      <= sample_next;
            cur_reg         <= cur_next;
            ge_reg          <= ge_next;
            delta_reg       <= delta_next;
            g_reg           <= g_next;
            acc_reg         <= acc_next;
            fire_reg        <= fire_next;
            hit_task_reg    <= hit_task_next;
            n_reg           <= n_next;
            pend_reg        <= pend_next;
        end
    end

    assign status.busy       = (state_reg != S_IDLE);
    assign status.pend_valid = pend_reg.valid;

endmodule

// ===== hw/rtl/time_triggered_task_dispatcher.sv =====
// Load and clear beats leave the block idle, ready again the next cycle. A sample
// keeps it busy through stamp, order, delta, then accumulate, due and wrap per
// closed group and a flush (no group: done after delta), sharing one 32-bit ALU
// and the entry RAM's single read port. A stalled result port stretches the walk.
// Reset (async, active low) clears control and group state; the entry RAM is
// not cleared, and its entries are only read after being loaded.
module time_triggered_task_dispatcher #(
    parameter int TABLE_DEPTH = 64,
    parameter int GROUPS      = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [ttd_pkg::TASK_W-1:0]     entry_task,
    input  logic [ttd_pkg::OFFSET_W-1:0]   entry_offset,
    input  logic [ttd_pkg::TIME_W-1:0]     entry_time,
    input  logic [ttd_pkg::STAMP_W-1:0]    counter_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ttd_pkg::TASK_W-1:0]     fired_task,
    output logic [ttd_pkg::POS_OUT_W-1:0]  fired_position,
    output logic [ttd_pkg::GRP_OUT_W-1:0]  fired_group,
    output logic                           last
);
    import ttd_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    entry_t               mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    entry_t               mem_rdata;
    logic                 out_free;
    result_t              push;
    status_t              status;

    logic                 out_valid_reg;
    logic [TASK_W-1:0]    out_task_reg;
    logic [POS_OUT_W-1:0] out_pos_reg;
    logic [GRP_OUT_W-1:0] out_grp_reg;
    logic                 out_last_reg;

    ttd_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ttd_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .GROUPS      (GROUPS),
        .AW          (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_valid && !in_stall),
        .kind          (kind),
        .entry_task    (entry_task),
        .entry_offset  (entry_offset),
        .entry_time    (entry_time),
        .counter_value (counter_value),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .out_free      (out_free),
        .push          (push),
        .status        (status)
    );

    assign in_stall = status.busy;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // load the output beat only when the slot is free
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_task_reg <= push.task_id;
            out_pos_reg  <= push.position;
            out_grp_reg  <= push.group;
            out_last_reg <= push.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fired_task     = out_task_reg;
    assign fired_position = out_pos_reg;
    assign fired_group    = out_grp_reg;
    assign last           = out_last_reg;

    `ASSERT_NOW(a_push_slot_free, push.valid, out_free, "result pushed into an occupied output slot")
    `ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && kind == KIND_SAMPLE, status.busy, "sample beat did not start the group walk")
    `ASSERT_NEXT(a_load_ready, in_valid && !in_stall && kind == KIND_LOAD, !status.busy, "load beat left the block busy")
    `ASSERT_NOW(a_idle_no_pending, !status.busy, !status.pend_valid, "pending result left behind when idle")

endmodule
